[rtl/core/tmg_pkg.sv]
// Shared types, codes and the divider step function of the trapezoid membership block.
`timescale 1ns / 1ps
package tmg_pkg;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int Q_W = 24;
	localparam int DIV1_STEPS = 24;
	localparam int DIV2_STEPS = 24;
	localparam int N_STAGES = DIV1_STEPS + DIV2_STEPS;

	localparam logic [1:0] REG_SUPPORT_LOW = 2'd0;
	localparam logic [1:0] REG_CORE_LOW = 2'd1;
	localparam logic [1:0] REG_CORE_HIGH = 2'd2;
	localparam logic [1:0] REG_SUPPORT_HIGH = 2'd3;

	localparam logic [2:0] CLS_ZERO = 3'd0;
	localparam logic [2:0] CLS_ERR = 3'd1;
	localparam logic [2:0] CLS_CORE = 3'd2;
	localparam logic [2:0] CLS_LEFT = 3'd3;
	localparam logic [2:0] CLS_RIGHT = 3'd4;

	localparam logic [15:0] MEMBERSHIP_ONE = 16'h8000;

	typedef struct packed {
		logic [2:0] cls;
		logic [15:0] num;
		logic [15:0] span;
	} front_item_t;

	typedef struct packed {
		logic [2:0] cls;
		logic [15:0] span;
		logic [15:0] rem_a;
		logic [15:0] rem_b;
		logic [Q_W-1:0] q_a;
		logic [Q_W-1:0] q_b;
		logic [Q_W-1:0] dv_a;
		logic [Q_W-1:0] dv_b;
		logic [Q_W-1:0] q1;
	} back_stage_t;

	function automatic logic [16:0] div_step(input logic [15:0] rem, input logic in_bit,
			input logic [15:0] span);
		logic [16:0] t;
		logic [16:0] d;
		t = {rem, in_bit};
		d = t - {1'b0, span};
		if (t >= {1'b0, span}) begin
			div_step = {d[15:0], 1'b1};
		end else begin
			div_step = {t[15:0], 1'b0};
		end
	endfunction
endpackage

[rtl/core/trapezoid_membership_grad.sv]
// Top level of the trapezoidal fuzzy membership block with breakpoint gradients.
`timescale 1ns / 1ps
// One sample is accepted per clock and one result leaves per clock in steady state, as long as
// results are popped as they appear. Each item passes the classifier register, the queue, the
// pipelined restoring dividers (first the slope quotient, then the two gradient quotients) and
// the result register. A result that waits for pop stalls the whole divider pipeline.
module trapezoid_membership_grad import tmg_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic push,
	output logic full,
	input logic [15:0] sample,
	output logic empty,
	input logic pop,
	output logic [15:0] membership,
	output logic [31:0] d_support_low,
	output logic [31:0] d_core_low,
	output logic [31:0] d_core_high,
	output logic [31:0] d_support_high,
	output logic order_error
);
	logic f_valid, f_ready, b_valid, b_ready;
	front_item_t f_item, b_item;

	tmg_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .sample(sample),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	tmg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	tmg_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.empty(empty), .pop(pop),
		.membership(membership),
		.d_support_low(d_support_low), .d_core_low(d_core_low),
		.d_core_high(d_core_high), .d_support_high(d_support_high),
		.order_error(order_error)
	);
endmodule

[rtl/core/tmg_front.sv]
// Front part: breakpoint registers, sample classification and slope operands.
`timescale 1ns / 1ps
module tmg_front import tmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic push,
	output logic full,
	input logic [15:0] sample,
	output logic item_valid,
	input logic item_ready,
	output front_item_t item
);
	logic signed [15:0] a_q, b_q, c_q, d_q;
	logic v_s1;
	front_item_t item_s1;
	front_item_t cls_item;
	logic load;
	logic signed [15:0] x;
	logic [16:0] diff_p, diff_s;
	logic left;

	assign cfg_ready = 1'b1;
	assign load = !v_s1 || item_ready;
	assign full = !load;
	assign item_valid = v_s1;
	assign item = item_s1;
	assign x = $signed(sample);
	assign left = x < b_q;

	always_comb begin
		if (left) begin
			diff_p = {x[15], x} - {a_q[15], a_q};
			diff_s = {b_q[15], b_q} - {a_q[15], a_q};
		end else begin
			diff_p = {d_q[15], d_q} - {x[15], x};
			diff_s = {d_q[15], d_q} - {c_q[15], c_q};
		end
		cls_item.num = diff_p[15:0];
		cls_item.span = diff_s[15:0];
		if (a_q > b_q || c_q > d_q) begin
			cls_item.cls = CLS_ERR;
		end else if (x <= a_q || x >= d_q) begin
			cls_item.cls = CLS_ZERO;
		end else if (x >= b_q && x <= c_q) begin
			cls_item.cls = CLS_CORE;
		end else if (left) begin
			cls_item.cls = CLS_LEFT;
		end else begin
			cls_item.cls = CLS_RIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= -16'sd32768;
			b_q <= 16'sd0;
			c_q <= 16'sd0;
			d_q <= 16'sd32767;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SUPPORT_LOW: a_q <= $signed(cfg_data);
				REG_CORE_LOW: b_q <= $signed(cfg_data);
				REG_CORE_HIGH: c_q <= $signed(cfg_data);
				REG_SUPPORT_HIGH: d_q <= $signed(cfg_data);
				default: a_q <= a_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (load && push) begin
			item_s1 <= cls_item;
		end
	end
endmodule

[rtl/core/tmg_queue.sv]
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
module tmg_queue import tmg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input front_item_t wr_item,
	output logic rd_valid,
	input logic rd_ready,
	output front_item_t rd_item
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	front_item_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end
endmodule

[rtl/core/tmg_back.sv]
// Back part: pipelined dividers for membership and gradients, and the result register.
`timescale 1ns / 1ps
module tmg_back import tmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input front_item_t in_item,
	output logic empty,
	input logic pop,
	output logic [15:0] membership,
	output logic [31:0] d_support_low,
	output logic [31:0] d_core_low,
	output logic [31:0] d_core_high,
	output logic [31:0] d_support_high,
	output logic order_error
);
	back_stage_t st_q [N_STAGES];
	back_stage_t st_d [N_STAGES];
	logic [N_STAGES-1:0] v_q;
	logic adv;
	logic out_valid_q;
	back_stage_t last;
	logic [31:0] neg_a, neg_b, pos_a, pos_b;

	assign adv = !out_valid_q || pop;
	assign in_ready = adv;
	assign empty = !out_valid_q;

	genvar k;
	generate
		for (k = 0; k < N_STAGES; k++) begin : g_stage
			back_stage_t src;
			logic [16:0] ra, rb;
			logic [Q_W:0] comp;
			always_comb begin
				if (k == 0) begin
					src = '0;
					src.cls = in_item.cls;
					src.span = in_item.span;
					src.rem_a = in_item.num;
				end else if (k == DIV1_STEPS) begin
					src = st_q[k-1];
					comp = {1'b1, {Q_W{1'b0}}} - {1'b0, st_q[k-1].q_a}
						- (Q_W + 1)'(st_q[k-1].rem_a != '0);
					src.q1 = st_q[k-1].q_a;
					src.dv_a = st_q[k-1].q_a;
					src.dv_b = comp[Q_W-1:0];
					src.rem_a = '0;
					src.rem_b = '0;
					src.q_a = '0;
					src.q_b = '0;
				end else begin
					src = st_q[k-1];
				end
				if (k != DIV1_STEPS) begin
					comp = '0;
				end
				st_d[k] = src;
				if (k < DIV1_STEPS) begin
					ra = div_step(src.rem_a, 1'b0, src.span);
					rb = '0;
					st_d[k].rem_a = ra[16:1];
					st_d[k].q_a = {src.q_a[Q_W-2:0], ra[0]};
				end else begin
					ra = div_step(src.rem_a, src.dv_a[Q_W-1], src.span);
					rb = div_step(src.rem_b, src.dv_b[Q_W-1], src.span);
					st_d[k].rem_a = ra[16:1];
					st_d[k].rem_b = rb[16:1];
					st_d[k].q_a = {src.q_a[Q_W-2:0], ra[0]};
					st_d[k].q_b = {src.q_b[Q_W-2:0], rb[0]};
					st_d[k].dv_a = {src.dv_a[Q_W-2:0], 1'b0};
					st_d[k].dv_b = {src.dv_b[Q_W-2:0], 1'b0};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (adv) begin
					v_q[k] <= (k == 0) ? in_valid : v_q[(k == 0) ? 0 : k - 1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					st_q[k] <= st_d[k];
				end
			end
		end
	endgenerate

	assign last = st_q[N_STAGES-1];
	assign pos_a = {{(32 - Q_W){1'b0}}, last.q_a};
	assign pos_b = {{(32 - Q_W){1'b0}}, last.q_b};
	assign neg_a = 32'd0 - pos_a;
	assign neg_b = 32'd0 - pos_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_q[N_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			membership <= '0;
			d_support_low <= '0;
			d_core_low <= '0;
			d_core_high <= '0;
			d_support_high <= '0;
			order_error <= 1'b0;
			unique case (last.cls)
				CLS_ERR: order_error <= 1'b1;
				CLS_CORE: membership <= MEMBERSHIP_ONE;
				CLS_LEFT: begin
					membership <= {1'b0, last.q1[Q_W-1:Q_W-15]};
					d_support_low <= neg_b;
					d_core_low <= neg_a;
				end
				CLS_RIGHT: begin
					membership <= {1'b0, last.q1[Q_W-1:Q_W-15]};
					d_core_high <= pos_a;
					d_support_high <= pos_b;
				end
				default: order_error <= 1'b0;
			endcase
		end
	end
endmodule
